[rtl/assert_macros.svh]
// Assertion macros shared by the decoder RTL.
// Every macro samples on the rising edge of clock and is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// When the trigger holds at an edge, the consequence must hold at the same edge.
`define ASSERT_IMPLIES(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) \
      else $error(msg);

`endif

[rtl/u8dec_pkg.sv]
// Types and constants for the UTF-8 stream decoder.
// No dependencies; used by the channel interfaces and the core.
package u8dec_pkg;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_ILLEGAL    = 2'd1,
      STATUS_INCOMPLETE = 2'd2
   } status_type;

   typedef logic [20:0] code_point_type;

   localparam code_point_type REPLACEMENT_CHAR = 21'h00FFFD;
   localparam code_point_type MAX_SCALAR       = 21'h10FFFF;
   localparam code_point_type SURROGATE_LO     = 21'h00D800;
   localparam code_point_type SURROGATE_HI     = 21'h00DFFF;

   localparam logic [7:0] ASCII_LIMIT   = 8'h80;
   localparam logic [7:0] LEAD_MIN      = 8'hC2;
   localparam logic [7:0] LEAD_THREE    = 8'hE0;
   localparam logic [7:0] LEAD_FOUR     = 8'hF0;
   localparam logic [7:0] LEAD_MAX      = 8'hF4;
   localparam logic [7:0] LEAD_ED       = 8'hED;
   localparam logic [7:0] CONT_MIN      = 8'h80;
   localparam logic [7:0] CONT_MAX      = 8'hBF;
   localparam logic [7:0] CONT_MIN_E0   = 8'hA0;
   localparam logic [7:0] CONT_MAX_ED   = 8'h9F;
   localparam logic [7:0] CONT_MIN_F0   = 8'h90;
   localparam logic [7:0] CONT_MAX_F4   = 8'h8F;

endpackage

[rtl/u8dec_ifs.sv]
// Valid/ready channel interfaces for the UTF-8 stream decoder.
// Depends on u8dec_pkg for the result types.
interface u8dec_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_input;

   modport source (output valid, output data_byte, output end_of_input, input ready);
   modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface u8dec_rsp_if;
   logic                    valid;
   logic                    ready;
   u8dec_pkg::code_point_type code_point;
   u8dec_pkg::status_type     status;

   modport source (output valid, output code_point, output status, input ready);
   modport sink   (input valid, input code_point, input status, output ready);
endinterface

[rtl/utf8_stream_decoder_core.sv]
// Strict UTF-8 to Unicode scalar decoder, one byte per item.
// Depends on u8dec_pkg, the channel interfaces in u8dec_ifs.sv and assert_macros.svh.
//
// Usage:
//   req_chan carries one byte of the UTF-8 stream per item, with end_of_input
//   marking the final byte. rsp_chan carries zero or one result per byte: a
//   code point with status ok, an illegal-sequence report, or an incomplete
//   report when the marked last byte leaves a sequence open. Error results
//   carry a code point of zero.
//   An accepted byte is held in the input register, and its result, if any, is
//   registered in the result register once that register is free, and is then
//   offered on rsp_chan.
//   Throughput: one byte per cycle while rsp_chan does not stall; the only loop
//   is the sequence state, which updates from the input register.
//   Reset (synchronous, active high) empties both registers and returns the
//   decoder to idle with no sequence open.
//   When the receiver stalls, the result register holds its item and the input
//   register holds one more byte; req_chan.ready then drops until rsp_chan moves.
`include "assert_macros.svh"

module utf8_stream_decoder_core (
   input  logic              clock,
   input  logic              reset,
   u8dec_req_if.sink         req_chan,
   u8dec_rsp_if.source       rsp_chan
);

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // Sequence state.
   logic [1:0]                remain_ff, remain_in;
   u8dec_pkg::code_point_type partial_ff, partial_in;
   logic [7:0]                lead_ff, lead_in;
   logic                      second_ff, second_in;

   // Result register.
   logic                      out_valid_ff, out_valid_in;
   u8dec_pkg::code_point_type out_cp_ff, out_cp_in;
   u8dec_pkg::status_type     out_st_ff, out_st_in;

   logic                      out_free, advance, req_take;
   logic                      emit;
   u8dec_pkg::code_point_type emit_cp;
   u8dec_pkg::status_type     emit_st;
   logic [7:0]                cont_lo, cont_hi;
   logic                      cont_ok;
   u8dec_pkg::code_point_type shifted;

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.code_point = out_cp_ff;
   assign rsp_chan.status     = out_st_ff;

   // Range allowed for the next continuation byte.
   always_comb begin
      cont_lo = u8dec_pkg::CONT_MIN;
      cont_hi = u8dec_pkg::CONT_MAX;
      if (second_ff) begin
         case (lead_ff)
            u8dec_pkg::LEAD_THREE: cont_lo = u8dec_pkg::CONT_MIN_E0;
            u8dec_pkg::LEAD_ED:    cont_hi = u8dec_pkg::CONT_MAX_ED;
            u8dec_pkg::LEAD_FOUR:  cont_lo = u8dec_pkg::CONT_MIN_F0;
            u8dec_pkg::LEAD_MAX:   cont_hi = u8dec_pkg::CONT_MAX_F4;
            default: ;
         endcase
      end
   end

   assign cont_ok = (in_byte_ff >= cont_lo) && (in_byte_ff <= cont_hi);
   assign shifted = {partial_ff[14:0], in_byte_ff[5:0]};

   // Decode step for the byte in the input register.
   always_comb begin
      emit       = 1'b0;
      emit_cp    = '0;
      emit_st    = u8dec_pkg::STATUS_OK;
      remain_in  = remain_ff;
      partial_in = partial_ff;
      lead_in    = lead_ff;
      second_in  = second_ff;
      if (remain_ff == 2'd0) begin
         if (in_byte_ff < u8dec_pkg::ASCII_LIMIT) begin
            emit    = 1'b1;
            emit_cp = {13'd0, in_byte_ff};
         end else if (in_byte_ff < u8dec_pkg::LEAD_MIN || in_byte_ff > u8dec_pkg::LEAD_MAX) begin
            emit    = 1'b1;
            emit_st = u8dec_pkg::STATUS_ILLEGAL;
         end else if (in_last_ff) begin
            emit    = 1'b1;
            emit_st = u8dec_pkg::STATUS_INCOMPLETE;
         end else begin
            lead_in   = in_byte_ff;
            second_in = 1'b1;
            if (in_byte_ff < u8dec_pkg::LEAD_THREE) begin
               remain_in  = 2'd1;
               partial_in = {16'd0, in_byte_ff[4:0]};
            end else if (in_byte_ff < u8dec_pkg::LEAD_FOUR) begin
               remain_in  = 2'd2;
               partial_in = {17'd0, in_byte_ff[3:0]};
            end else begin
               remain_in  = 2'd3;
               partial_in = {18'd0, in_byte_ff[2:0]};
            end
         end
      end else if (!cont_ok) begin
         emit      = 1'b1;
         emit_st   = u8dec_pkg::STATUS_ILLEGAL;
         remain_in = 2'd0;
         second_in = 1'b0;
      end else if (remain_ff == 2'd1) begin
         emit      = 1'b1;
         remain_in = 2'd0;
         second_in = 1'b0;
         if (shifted > u8dec_pkg::MAX_SCALAR ||
             (shifted >= u8dec_pkg::SURROGATE_LO && shifted <= u8dec_pkg::SURROGATE_HI)) begin
            emit_cp = u8dec_pkg::REPLACEMENT_CHAR;
         end else begin
            emit_cp = shifted;
         end
      end else if (in_last_ff) begin
         emit      = 1'b1;
         emit_st   = u8dec_pkg::STATUS_INCOMPLETE;
         remain_in = 2'd0;
         second_in = 1'b0;
      end else begin
         remain_in  = remain_ff - 2'd1;
         partial_in = shifted;
         second_in  = 1'b0;
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_cp_in    = out_cp_ff;
      out_st_in    = out_st_ff;
      if (out_free) begin
         out_valid_in = advance && emit;
         out_cp_in    = emit_cp;
         out_st_in    = emit_st;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         remain_ff    <= 2'd0;
         partial_ff   <= '0;
         lead_ff      <= '0;
         second_ff    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            remain_ff  <= remain_in;
            partial_ff <= partial_in;
            lead_ff    <= lead_in;
            second_ff  <= second_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.data_byte;
         in_last_ff <= req_chan.end_of_input;
      end
      out_cp_ff <= out_cp_in;
      out_st_ff <= out_st_in;
   end

   // An error result never carries a code point.
   `ASSERT_IMPLIES(a_err_zero_cp, out_valid_ff && out_st_ff != u8dec_pkg::STATUS_OK,
      out_cp_ff == '0, "error result with nonzero code point")

   // A good result is always a Unicode scalar value.
   `ASSERT_IMPLIES(a_ok_scalar, out_valid_ff && out_st_ff == u8dec_pkg::STATUS_OK,
      out_cp_ff <= u8dec_pkg::MAX_SCALAR &&
      !(out_cp_ff >= u8dec_pkg::SURROGATE_LO && out_cp_ff <= u8dec_pkg::SURROGATE_HI),
      "ok result outside the scalar range")

   // An open sequence always has a legal multi-byte lead.
   `ASSERT_IMPLIES(a_open_lead, remain_ff != 2'd0,
      lead_ff >= u8dec_pkg::LEAD_MIN && lead_ff <= u8dec_pkg::LEAD_MAX,
      "open sequence with an illegal lead byte")

   // The second-byte flag is only set while a sequence is open.
   `ASSERT_ALWAYS(a_second_open, !second_ff || remain_ff != 2'd0,
      "second-byte flag set while idle")

endmodule
